// ===== sv/mkpc_pkg.sv =====
// Package for the multi-key press classifier: widths, register indexes,
// command codes and timing constants. No dependencies.
package mkpc_pkg;

   localparam int KEY_COUNT   = 8;
   localparam int KEY_IDX_W   = 3;
   localparam int KEY_NUM_W   = 4;
   localparam int CNT_W       = 16;
   localparam int STATUS_W    = 32;
   localparam int BEEP_W      = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_KEYS_IN_USE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUZZER_ENABLE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASED_LEVEL = 3'd5;

   // Command codes carried in tuser.
   localparam logic FUNC_SCAN  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // Bit positions inside one key's status nibble.
   localparam int ST_PRESSED  = 0;
   localparam int ST_LONG     = 1;
   localparam int ST_RELEASED = 2;
   localparam int ST_OVER     = 3;

   localparam logic [BEEP_W-1:0] BEEP_LENGTH = 6'd50;
   localparam logic [BEEP_W-1:0] BEEP_HALF   = 6'd25;
   localparam logic [CNT_W:0]    LIMIT_SLACK = 17'd5;
   localparam logic [CNT_W-1:0]  CNT_TOP     = 16'hFFFF;

   localparam logic [CNT_W-1:0]    RST_DEBOUNCE    = 16'd20;
   localparam logic [CNT_W-1:0]    RST_LONG_PRESS  = 16'd1000;
   localparam logic [CNT_W-1:0]    RST_PRESS_LIMIT = 16'd6000;
   localparam logic [KEY_NUM_W-1:0] KEY_COUNT_NUM  = 4'd8;

endpackage

// ===== sv/multi_key_press_classifier_core.sv =====
// Multi-key press classifier: a small sequencer that visits one key per cycle
// through a shared compare and count unit. Uses mkpc_pkg.
//
// Sequence: a scan word visits each of the n effective keys in turn, then updates
// the buzzer, then loads the output register; a clear goes through S_CLEAR to the
// output load, and a scan with the scanner closed goes straight to the output load.
// req_tready returns in the same cycle that rsp_tvalid rises, so a new word is not
// taken until the last one's result is loaded; the per-key walk sets the rate, and
// a held result stalls it further.
// Reset (synchronous, active high) clears counters and status, silences the
// buzzer and loads the register defaults; no clearing pass is needed.
module multi_key_press_classifier_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: key_levels [7:0], key_id [15:8]
   input  logic [mkpc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: func
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata: key_status_word [31:0], buzzer_pin [32], cmd_error [33], zero [39:34]
   output logic [mkpc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic [mkpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mkpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_BUZZ  = 3'd2;
   localparam logic [2:0] S_CLEAR = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // Configuration registers.
   logic [mkpc_pkg::KEY_NUM_W-1:0] keys_in_use_ff;
   logic [mkpc_pkg::CNT_W-1:0]     debounce_ff;
   logic [mkpc_pkg::CNT_W-1:0]     long_press_ff;
   logic [mkpc_pkg::CNT_W-1:0]     press_limit_ff;
   logic                           buzzer_enable_ff;
   logic                           released_level_ff;

   // Sequencer and block state.
   logic [2:0]                     state_ff, state_in;
   logic [mkpc_pkg::KEY_IDX_W-1:0] key_ff, key_in;
   logic [mkpc_pkg::CNT_W-1:0]     counter_ff [mkpc_pkg::KEY_COUNT];
   logic [mkpc_pkg::CNT_W-1:0]     counter_in;
   logic                           counter_we;
   logic [mkpc_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [mkpc_pkg::BEEP_W-1:0]    beep_ff, beep_in;
   logic                           buzzer_ff, buzzer_in;

   // Latched input word and error flag.
   logic [7:0] levels_ff;
   logic [7:0] key_id_ff;
   logic       err_ff, err_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mkpc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [mkpc_pkg::KEY_NUM_W-1:0] active_keys;
   logic                           accept;
   logic [4:0]                     nib_base;
   logic [3:0]                     nib, nib_new;
   logic [mkpc_pkg::CNT_W-1:0]     cnt, cnt_mid;
   logic                           level;
   logic                           clear_all;
   logic                           out_free;

   assign active_keys = (keys_in_use_ff > mkpc_pkg::KEY_COUNT_NUM)
                        ? mkpc_pkg::KEY_COUNT_NUM : keys_in_use_ff;
   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   // Shared per-key unit: the key under the sequencer's index is examined.
   assign nib_base = {key_ff, 2'b00};
   assign nib      = status_ff[nib_base +: 4];
   assign cnt      = counter_ff[key_ff];
   assign level    = levels_ff[key_ff];

   always_comb begin
      nib_new   = nib;
      cnt_mid   = cnt;
      clear_all = 1'b0;
      beep_in   = beep_ff;
      if (!nib[mkpc_pkg::ST_RELEASED]) begin
         if (level != released_level_ff) begin
            if (!nib[mkpc_pkg::ST_PRESSED]) begin
               if (cnt == '0) begin
                  cnt_mid = {{(mkpc_pkg::CNT_W-1){1'b0}}, 1'b1};
               end
               if (cnt_mid > debounce_ff) begin
                  nib_new[mkpc_pkg::ST_PRESSED] = 1'b1;
               end
            end else if (!nib[mkpc_pkg::ST_LONG]) begin
               if (cnt > long_press_ff && cnt <= press_limit_ff) begin
                  nib_new[mkpc_pkg::ST_LONG] = 1'b1;
               end
            end else if (!nib[mkpc_pkg::ST_OVER]) begin
               if (cnt > press_limit_ff) begin
                  nib_new[mkpc_pkg::ST_OVER] = 1'b1;
               end
            end
         end else begin
            if (nib[mkpc_pkg::ST_PRESSED] && !nib[mkpc_pkg::ST_OVER]) begin
               nib_new[mkpc_pkg::ST_RELEASED] = 1'b1;
               if (beep_ff == '0) begin
                  beep_in = mkpc_pkg::BEEP_LENGTH;
               end
            end else if (nib[mkpc_pkg::ST_OVER]) begin
               clear_all = 1'b1;
            end
            cnt_mid = '0;
         end
      end
      counter_in = cnt_mid;
      // The counter stops at the limit plus its slack, or at its top value, and never wraps.
      if (cnt_mid != '0 && ({1'b0, cnt_mid} < ({1'b0, press_limit_ff} + mkpc_pkg::LIMIT_SLACK))
          && cnt_mid != mkpc_pkg::CNT_TOP) begin
         counter_in = cnt_mid + {{(mkpc_pkg::CNT_W-1){1'b0}}, 1'b1};
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      buzzer_in    = buzzer_ff;
      err_in       = err_ff;
      counter_we   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in = '0;
               err_in = 1'b0;
               if (req_tuser == mkpc_pkg::FUNC_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (active_keys == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            counter_we = 1'b1;
            if (clear_all) begin
               status_in = '0;
            end else begin
               status_in[nib_base +: 4] = nib_new;
            end
            if ({1'b0, key_ff} == active_keys - 4'd1) begin
               state_in = S_BUZZ;
            end else begin
               key_in = key_ff + 3'd1;
            end
         end
         S_BUZZ: begin
            if (beep_ff != '0) begin
               if (beep_ff > mkpc_pkg::BEEP_HALF) begin
                  if (buzzer_enable_ff) begin
                     buzzer_in = 1'b0;
                  end
               end else begin
                  buzzer_in = 1'b1;
               end
            end
            state_in = S_DONE;
         end
         S_CLEAR: begin
            if (key_id_ff >= {4'b0000, active_keys}) begin
               err_in = 1'b1;
            end else begin
               status_in[{key_id_ff[mkpc_pkg::KEY_IDX_W-1:0], 2'b00} +: 4] = 4'b0000;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b000000, err_ff, buzzer_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_in_use_ff    <= '0;
         debounce_ff       <= mkpc_pkg::RST_DEBOUNCE;
         long_press_ff     <= mkpc_pkg::RST_LONG_PRESS;
         press_limit_ff    <= mkpc_pkg::RST_PRESS_LIMIT;
         buzzer_enable_ff  <= 1'b0;
         released_level_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            mkpc_pkg::REG_KEYS_IN_USE:    keys_in_use_ff    <= csr_wdata[3:0];
            mkpc_pkg::REG_DEBOUNCE:       debounce_ff       <= csr_wdata;
            mkpc_pkg::REG_LONG_PRESS:     long_press_ff     <= csr_wdata;
            mkpc_pkg::REG_PRESS_LIMIT:    press_limit_ff    <= csr_wdata;
            mkpc_pkg::REG_BUZZER_ENABLE:  buzzer_enable_ff  <= csr_wdata[0];
            mkpc_pkg::REG_RELEASED_LEVEL: released_level_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_ff       <= '0;
         status_ff    <= '0;
         beep_ff      <= '0;
         buzzer_ff    <= 1'b1;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < mkpc_pkg::KEY_COUNT; i++) begin
            counter_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         status_ff    <= status_in;
         buzzer_ff    <= buzzer_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_SCAN) begin
            beep_ff <= beep_in;
         end else if (state_ff == S_BUZZ && beep_ff != '0) begin
            beep_ff <= beep_ff - 6'd1;
         end
         if (counter_we) begin
            counter_ff[key_ff] <= counter_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         levels_ff <= req_tdata[7:0];
         key_id_ff <= req_tdata[15:8];
      end
   end

endmodule
